// File: rtl/bme_pkg.sv
// shared constants, types and the cosine ease table for the blended motion easing block
`default_nettype none

package bme_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int IN_W        = FRAC_BITS + 2;
   localparam int OUT_W       = FRAC_BITS + 1;
   localparam int CSR_W       = OUT_W;
   localparam int COS_ENTRIES = 256;
   localparam int IDX_W       = $clog2(COS_ENTRIES + 1);
   localparam int POS_W       = FRAC_BITS + $clog2(2 * COS_ENTRIES + 1);

   localparam logic [OUT_W-1:0]     ONE_Q       = OUT_W'(1) << FRAC_BITS;
   localparam logic [OUT_W-1:0]     ALPHA_RESET = ONE_Q >> 2;
   localparam logic [FRAC_BITS-1:0] HALF_LSB    = FRAC_BITS'(1) << (FRAC_BITS - 1);

   typedef enum logic [0:0] {
      CSR_BLEND_ENABLE = 1'b0,
      CSR_BLEND_ALPHA  = 1'b1
   } csr_index_type;

   typedef logic [OUT_W-1:0] cos_table_type [0:COS_ENTRIES];

   localparam longint unsigned PI_Q30   = 64'd3373259426;
   localparam longint unsigned Q30_ONE  = 64'd1 << 30;
   localparam longint unsigned COS_SPAN = 64'(2 * COS_ENTRIES);

   // entry i = 0.5 * (1 - cos(pi * i / (2N))), from a truncated q30 taylor series
   function automatic cos_table_type build_cos_table();
      cos_table_type    tbl;
      longint unsigned  y;
      longint unsigned  y2;
      longint unsigned  term;
      longint           c;
      longint           f;
      for (int i = 0; i <= COS_ENTRIES; i++) begin
         y    = (PI_Q30 * longint'(i)) / COS_SPAN;
         y2   = (y * y) >> 30;
         term = Q30_ONE;
         c    = longint'(Q30_ONE);
         // ten alternating terms, term k divided by (2k-1)(2k)
         term = ((term * y2) >> 30) / 64'd2;
         c    = c - longint'(term);
         term = ((term * y2) >> 30) / 64'd12;
         c    = c + longint'(term);
         term = ((term * y2) >> 30) / 64'd30;
         c    = c - longint'(term);
         term = ((term * y2) >> 30) / 64'd56;
         c    = c + longint'(term);
         term = ((term * y2) >> 30) / 64'd90;
         c    = c - longint'(term);
         term = ((term * y2) >> 30) / 64'd132;
         c    = c + longint'(term);
         term = ((term * y2) >> 30) / 64'd182;
         c    = c - longint'(term);
         term = ((term * y2) >> 30) / 64'd240;
         c    = c + longint'(term);
         term = ((term * y2) >> 30) / 64'd306;
         c    = c - longint'(term);
         term = ((term * y2) >> 30) / 64'd380;
         c    = c + longint'(term);
         f = (longint'(Q30_ONE) - c) / 2;
         if (f < 0) begin
            f = 0;
         end
         if (f > longint'(Q30_ONE / 2)) begin
            f = longint'(Q30_ONE / 2);
         end
         tbl[i] = OUT_W'((longint'(f) + (longint'(1) << (29 - FRAC_BITS)))
                         >> (30 - FRAC_BITS));
      end
      return tbl;
   endfunction

   localparam cos_table_type COS_TABLE = build_cos_table();

endpackage

`default_nettype wire

// File: rtl/bme_if.sv
// valid/ready channel interfaces for progress samples and eased results
`default_nettype none

interface bme_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [bme_pkg::IN_W-1:0]     progress;

   modport source (output valid, output progress, input ready);
   modport sink   (input valid, input progress, output ready);
endinterface

interface bme_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [bme_pkg::OUT_W-1:0]    eased;

   modport source (output valid, output eased, input ready);
   modport sink   (input valid, input eased, output ready);
endinterface

`default_nettype wire

// File: rtl/blended_motion_easing.sv
// eased progress pipeline: quintic smootherstep blended with a table cosine ease
// throughput: one beat per cycle while rsp is not stalled
// eight register stages, at most two multipliers in any one
// a stalled rsp holds the full stages back to the first bubble, which still takes new beats
// reset (synchronous, active high) empties all stages and sets enable 0, alpha 0.25
`default_nettype none

module blended_motion_easing (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bme_req_if.sink                             req,
   bme_rsp_if.source                           rsp,
   input  wire logic                           csr_wr_en,
   input  wire logic [0:0]                     csr_index,
   input  wire logic [bme_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int F      = bme_pkg::FRAC_BITS;
   localparam int OW     = bme_pkg::OUT_W;
   localparam int IW     = bme_pkg::IN_W;
   localparam int STAGES = 8;
   localparam int Q_W    = F + 7;
   localparam int M_W    = 2 * OW + 2;
   localparam int D_W    = OW + F;

   function automatic logic [F-1:0] mul_q(input logic [F-1:0] a, input logic [F-1:0] b);
      logic [2*F-1:0] p;
      p = (2*F)'(a) * (2*F)'(b) + (2*F)'(bme_pkg::HALF_LSB);
      return p[2*F-1:F];
   endfunction

   // configuration
   logic          blend_en_ff;
   logic [OW-1:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_en_ff <= 1'b0;
         alpha_ff    <= bme_pkg::ALPHA_RESET;
      end else if (csr_wr_en) begin
         unique case (bme_pkg::csr_index_type'(csr_index))
            bme_pkg::CSR_BLEND_ENABLE: blend_en_ff <= csr_wdata[0];
            bme_pkg::CSR_BLEND_ALPHA:  alpha_ff    <= csr_wdata[OW-1:0];
            default: ;
         endcase
      end
   end

   // valid bits and per-stage load enables
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] stage_en;

   always_comb begin
      stage_en[STAGES-1] = !vld_ff[STAGES-1] || rsp.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in[0] = stage_en[0] ? req.valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req.ready = stage_en[0];
   assign rsp.valid = vld_ff[STAGES-1];

   // stage 0: classify the raw sample
   logic          s0_fixed_in, s0_fixed_ff;
   logic [OW-1:0] s0_fixval_in, s0_fixval_ff;
   logic [F-1:0]  s0_t_ff;
   logic          raw_neg, raw_ge_one, raw_zero;

   always_comb begin
      raw_neg      = req.progress[IW-1];
      raw_ge_one   = req.progress[F];
      raw_zero     = (req.progress == '0);
      s0_fixed_in  = raw_neg || raw_ge_one || raw_zero;
      s0_fixval_in = (!raw_neg && raw_ge_one) ? bme_pkg::ONE_Q : '0;
   end

   // stage 1: t^2 and cosine table lookup
   logic                       s1_fixed_ff;
   logic [OW-1:0]              s1_fixval_ff;
   logic [F-1:0]               s1_t_ff, s1_t2_ff, s1_t2_in;
   logic                       s1_mirror_ff, s1_mirror_in;
   logic [OW-1:0]              s1_lo_ff, s1_lo_in, s1_d_ff, s1_d_in;
   logic [F-1:0]               s1_frac_ff, s1_frac_in;
   logic [F-1:0]               cos_u;
   logic [bme_pkg::POS_W-1:0]  cos_pos;
   logic [bme_pkg::POS_W-F-1:0] cos_idx_full;
   logic [bme_pkg::IDX_W-1:0]  cos_idx;
   logic [OW-1:0]              cos_hi;

   always_comb begin
      s1_t2_in     = mul_q(s0_t_ff, s0_t_ff);
      s1_mirror_in = (s0_t_ff > bme_pkg::HALF_LSB);
      cos_u        = s1_mirror_in ? F'(bme_pkg::ONE_Q - {1'b0, s0_t_ff}) : s0_t_ff;
      cos_pos      = bme_pkg::POS_W'(cos_u) * bme_pkg::POS_W'(2 * bme_pkg::COS_ENTRIES);
      cos_idx_full = cos_pos[bme_pkg::POS_W-1:F];
      cos_idx      = cos_idx_full[bme_pkg::IDX_W-1:0];
      if (cos_idx_full >= (bme_pkg::POS_W-F)'(bme_pkg::COS_ENTRIES)) begin
         // top of the half range: no interpolation
         s1_lo_in   = bme_pkg::COS_TABLE[bme_pkg::COS_ENTRIES];
         cos_hi     = s1_lo_in;
         s1_frac_in = '0;
      end else begin
         s1_lo_in   = bme_pkg::COS_TABLE[cos_idx];
         cos_hi     = bme_pkg::COS_TABLE[cos_idx + bme_pkg::IDX_W'(1)];
         s1_frac_in = cos_pos[F-1:0];
      end
      s1_d_in = (cos_hi >= s1_lo_in) ? (cos_hi - s1_lo_in) : '0;
   end

   // stage 2: t^3 and interpolated, mirrored cosine ease
   logic          s2_fixed_ff;
   logic [OW-1:0] s2_fixval_ff;
   logic [F-1:0]  s2_t_ff, s2_t3_ff, s2_t3_in;
   logic [OW-1:0] s2_c_ff, s2_c_in;
   logic [D_W-1:0] cos_dprod;
   logic [OW:0]   cos_v;
   logic [OW-1:0] cos_vc;

   always_comb begin
      s2_t3_in  = mul_q(s1_t2_ff, s1_t_ff);
      cos_dprod = D_W'(s1_d_ff) * D_W'(s1_frac_ff) + D_W'(bme_pkg::HALF_LSB);
      cos_v     = (OW+1)'(s1_lo_ff) + (OW+1)'(cos_dprod >> F);
      cos_vc    = (cos_v > (OW+1)'(bme_pkg::ONE_Q)) ? bme_pkg::ONE_Q : cos_v[OW-1:0];
      s2_c_in   = s1_mirror_ff ? (bme_pkg::ONE_Q - cos_vc) : cos_vc;
   end

   // stage 3: t^4
   logic          s3_fixed_ff;
   logic [OW-1:0] s3_fixval_ff;
   logic [F-1:0]  s3_t_ff, s3_t3_ff, s3_t4_ff, s3_t4_in;
   logic [OW-1:0] s3_c_ff;

   assign s3_t4_in = mul_q(s2_t3_ff, s2_t_ff);

   // stage 4: t^5
   logic          s4_fixed_ff;
   logic [OW-1:0] s4_fixval_ff;
   logic [F-1:0]  s4_t3_ff, s4_t4_ff, s4_t5_ff, s4_t5_in;
   logic [OW-1:0] s4_c_ff;

   assign s4_t5_in = mul_q(s3_t4_ff, s3_t_ff);

   // stage 5: quintic polynomial, clamped
   logic                  s5_fixed_ff;
   logic [OW-1:0]         s5_fixval_ff;
   logic [OW-1:0]         s5_q_ff, s5_q_in;
   logic [OW-1:0]         s5_c_ff;
   logic signed [Q_W-1:0] q_sum;

   always_comb begin
      q_sum = $signed(Q_W'(s4_t3_ff) * Q_W'(10))
            - $signed(Q_W'(s4_t4_ff) * Q_W'(15))
            + $signed(Q_W'(s4_t5_ff) * Q_W'(6));
      if (q_sum < 0) begin
         s5_q_in = '0;
      end else if (q_sum > $signed(Q_W'(bme_pkg::ONE_Q))) begin
         s5_q_in = bme_pkg::ONE_Q;
      end else begin
         s5_q_in = q_sum[OW-1:0];
      end
   end

   // stage 6: alpha * (c - q); a zero weight when blending is off leaves q
   logic                  s6_fixed_ff;
   logic [OW-1:0]         s6_fixval_ff;
   logic [OW-1:0]         s6_q_ff;
   logic signed [M_W-1:0] s6_m_ff, s6_m_in;
   logic [OW-1:0]         alpha_eff;
   logic signed [OW:0]    blend_diff;

   always_comb begin
      if (!blend_en_ff) begin
         alpha_eff = '0;
      end else if (alpha_ff > bme_pkg::ONE_Q) begin
         alpha_eff = bme_pkg::ONE_Q;
      end else begin
         alpha_eff = alpha_ff;
      end
      blend_diff = $signed({1'b0, s5_c_ff}) - $signed({1'b0, s5_q_ff});
      s6_m_in    = M_W'($signed({1'b0, alpha_eff}) * blend_diff);
   end

   // stage 7: q + round(alpha * (c - q)), clamped, or the fixed end value
   logic [OW-1:0]         s7_eased_ff, s7_eased_in;
   logic signed [M_W-1:0] blend_sum;

   always_comb begin
      blend_sum = $signed(M_W'(s6_q_ff))
                + ((s6_m_ff + $signed(M_W'(bme_pkg::HALF_LSB))) >>> F);
      if (s6_fixed_ff) begin
         s7_eased_in = s6_fixval_ff;
      end else if (blend_sum < 0) begin
         s7_eased_in = '0;
      end else if (blend_sum > $signed(M_W'(bme_pkg::ONE_Q))) begin
         s7_eased_in = bme_pkg::ONE_Q;
      end else begin
         s7_eased_in = blend_sum[OW-1:0];
      end
   end

   assign rsp.eased = s7_eased_ff;

   // payload registers, loaded with their stage
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_fixed_ff  <= s0_fixed_in;
         s0_fixval_ff <= s0_fixval_in;
         s0_t_ff      <= req.progress[F-1:0];
      end
      if (stage_en[1]) begin
         s1_fixed_ff  <= s0_fixed_ff;
         s1_fixval_ff <= s0_fixval_ff;
         s1_t_ff      <= s0_t_ff;
         s1_t2_ff     <= s1_t2_in;
         s1_mirror_ff <= s1_mirror_in;
         s1_lo_ff     <= s1_lo_in;
         s1_d_ff      <= s1_d_in;
         s1_frac_ff   <= s1_frac_in;
      end
      if (stage_en[2]) begin
         s2_fixed_ff  <= s1_fixed_ff;
         s2_fixval_ff <= s1_fixval_ff;
         s2_t_ff      <= s1_t_ff;
         s2_t3_ff     <= s2_t3_in;
         s2_c_ff      <= s2_c_in;
      end
      if (stage_en[3]) begin
         s3_fixed_ff  <= s2_fixed_ff;
         s3_fixval_ff <= s2_fixval_ff;
         s3_t_ff      <= s2_t_ff;
         s3_t3_ff     <= s2_t3_ff;
         s3_t4_ff     <= s3_t4_in;
         s3_c_ff      <= s2_c_ff;
      end
      if (stage_en[4]) begin
         s4_fixed_ff  <= s3_fixed_ff;
         s4_fixval_ff <= s3_fixval_ff;
         s4_t3_ff     <= s3_t3_ff;
         s4_t4_ff     <= s3_t4_ff;
         s4_t5_ff     <= s4_t5_in;
         s4_c_ff      <= s3_c_ff;
      end
      if (stage_en[5]) begin
         s5_fixed_ff  <= s4_fixed_ff;
         s5_fixval_ff <= s4_fixval_ff;
         s5_q_ff      <= s5_q_in;
         s5_c_ff      <= s4_c_ff;
      end
      if (stage_en[6]) begin
         s6_fixed_ff  <= s5_fixed_ff;
         s6_fixval_ff <= s5_fixval_ff;
         s6_q_ff      <= s5_q_ff;
         s6_m_ff      <= s6_m_in;
      end
      if (stage_en[7]) begin
         s7_eased_ff  <= s7_eased_in;
      end
   end

   // input side only stalls once every stage holds a beat
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (&vld_ff))
      else $error("input stalled while the pipeline has a bubble");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.eased <= bme_pkg::ONE_Q))
      else $error("eased result above one");

   assert property (@(posedge clock) disable iff (reset)
      (stage_en[7] && vld_ff[6] && s6_fixed_ff) |=> (s7_eased_ff == $past(s6_fixval_ff)))
      else $error("out-of-range progress not mapped to its end value");

   assert property (@(posedge clock) disable iff (reset)
      (stage_en[7] && vld_ff[6] && !s6_fixed_ff && !blend_en_ff)
         |=> (s7_eased_ff == $past(s6_q_ff)))
      else $error("unblended result differs from the quintic ease");

endmodule

`default_nettype wire
